// ===== rtl/core/dht_pkg.sv =====
// ----------------------------------------------------------------------------
// dht_pkg
// Shared widths, codes and types of the double hashing key/value table.
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int TS_W     = 11;
    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 32;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int STEP_W   = 4;

    localparam int CAPACITY_DEFAULT = 1024;
    localparam int STEP_BASE        = 8;

    localparam logic [TS_W-1:0] TS_RESET = 11'd1024;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_CHECK,
        ST_FIN
    } state_t;

endpackage

// ===== rtl/core/double_hash_table.sv =====
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressing key/value table with double hashing.
// ----------------------------------------------------------------------------
// Requests (op, key, value) enter on in_valid/in_stall; one result (status,
// slot, found_value) leaves per request on out_valid/out_stall. A transfer
// happens on a clock edge with valid high and stall low.
// After reset the slot memory is swept clear, one slot per cycle; in_stall
// stays high meanwhile. table_size may be written through
// cfg_write_en/cfg_write_data at any time the table is idle.
// Per request: key mod the effective table size in the two-bit-per-cycle
// remainder unit, taking the remainder as the first probe slot, a first
// read, then the probes, paced by the single read port of the key memory,
// and the hand-over of the result to the output register, with probes from
// 1 to the effective table size. One request is in flight at a time.
// The output register frees the core: a new request is taken while a result
// waits under out_stall; only the hand-over of the next result waits for it.
// ----------------------------------------------------------------------------
module double_hash_table #(
    parameter int CAPACITY = dht_pkg::CAPACITY_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [dht_pkg::TS_W-1:0]     cfg_write_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [dht_pkg::KEY_W-1:0]    key,
    input  logic signed [dht_pkg::VALUE_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dht_pkg::STATUS_W-1:0] status,
    output logic [dht_pkg::SLOT_W-1:0]   slot,
    output logic signed [dht_pkg::VALUE_W-1:0] found_value
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LOC_W = (IDX_W > dht_pkg::TS_W) ? IDX_W : dht_pkg::TS_W;
    localparam int KW    = dht_pkg::KEY_W;
    localparam int VW    = dht_pkg::VALUE_W;
    localparam int SW    = dht_pkg::STEP_W;

    dht_pkg::state_t state_reg, state_next;

    logic [dht_pkg::TS_W-1:0] ts_reg;
    logic [IDX_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                     op_reg, op_next;
    logic [KW-1:0]            key_reg, key_next;
    logic [VW-1:0]            value_reg, value_next;
    logic [LOC_W-1:0]         n_reg, n_next;
    logic [LOC_W-1:0]         loc_reg, loc_next;
    logic [LOC_W-1:0]         step_reg, step_next;
    logic [LOC_W-1:0]         cnt_reg, cnt_next;
    logic [dht_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [dht_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [VW-1:0]            res_value_reg, res_value_next;
    logic                     out_valid_reg, out_valid_next;
    logic [dht_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [dht_pkg::SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [VW-1:0]            out_value_reg, out_value_next;

    logic [LOC_W-1:0]         n_eff;
    logic                     in_xfer;
    logic                     mod_done;
    logic [LOC_W-1:0]         mod_rem;
    logic [SW-1:0]            step_raw, step_small;
    logic [SW-1:0]            n_small;
    logic [LOC_W-1:0]         step_mod;
    logic [LOC_W:0]           loc_sum;
    logic [LOC_W-1:0]         loc_adv;
    logic [LOC_W-1:0]         cnt_inc;

    logic                     a_we;
    logic [IDX_W-1:0]         a_waddr;
    logic [KW:0]              a_wdata;
    logic [IDX_W-1:0]         rd_addr;
    logic [KW:0]              a_rdata;
    logic                     b_we;
    logic [VW-1:0]            b_rdata;
    logic                     slot_occ;
    logic                     key_hit;

    // table_size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= dht_pkg::TS_RESET;
        end
        else if (cfg_write_en)
        begin
            ts_reg <= cfg_write_data;
        end
    end

    // zero reads as one, above capacity saturates
    always_comb
    begin
        if (ts_reg == '0)
        begin
            n_eff = LOC_W'(1);
        end
        else if (32'(ts_reg) > 32'(CAPACITY))
        begin
            n_eff = LOC_W'(CAPACITY);
        end
        else
        begin
            n_eff = LOC_W'(ts_reg);
        end
    end

    assign in_stall = (state_reg != dht_pkg::ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    dht_mod #(
        .N_W (LOC_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_xfer),
        .dividend  (key),
        .divisor   (n_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // probe step (8 - key mod 8) mod n; only small n needs reducing
    always_comb
    begin
        step_raw   = SW'(dht_pkg::STEP_BASE) - {1'b0, key_reg[2:0]};
        n_small    = n_reg[SW-1:0];
        step_small = step_raw;
        for (int i = 0; i < dht_pkg::STEP_BASE; i++)
        begin
            if (step_small >= n_small)
            begin
                step_small = step_small - n_small;
            end
        end
        if (n_reg > LOC_W'(dht_pkg::STEP_BASE))
        begin
            step_mod = LOC_W'(step_raw);
        end
        else
        begin
            step_mod = LOC_W'(step_small);
        end
    end

    assign loc_sum = {1'b0, loc_reg} + {1'b0, step_reg};
    assign loc_adv = (loc_sum >= {1'b0, n_reg}) ? LOC_W'(loc_sum - {1'b0, n_reg})
                                                : loc_sum[LOC_W-1:0];
    assign cnt_inc = cnt_reg + 1'b1;

    assign slot_occ = a_rdata[KW];
    assign key_hit  = (a_rdata[KW-1:0] == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        n_next          = n_reg;
        loc_next        = loc_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_value_next  = out_value_reg;

        a_we    = 1'b0;
        a_waddr = loc_reg[IDX_W-1:0];
        a_wdata = {1'b1, key_reg};
        b_we    = 1'b0;
        rd_addr = loc_reg[IDX_W-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            dht_pkg::ST_CLEAR:
            begin
                a_we         = 1'b1;
                a_waddr      = clr_cnt_reg;
                a_wdata      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = dht_pkg::ST_IDLE;
                end
            end

            dht_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    key_next   = key;
                    value_next = value;
                    n_next     = n_eff;
                    state_next = dht_pkg::ST_DIV;
                end
            end

            dht_pkg::ST_DIV:
            begin
                if (mod_done)
                begin
                    loc_next   = mod_rem;
                    step_next  = step_mod;
                    cnt_next   = '0;
                    state_next = dht_pkg::ST_READ;
                end
            end

            dht_pkg::ST_READ:
            begin
                state_next = dht_pkg::ST_CHECK;
            end

            dht_pkg::ST_CHECK:
            begin
                // speculative read of the next probe slot
                rd_addr        = loc_adv[IDX_W-1:0];
                res_slot_next  = '0;
                res_value_next = '0;
                if (op_reg == dht_pkg::OP_INSERT && !slot_occ)
                begin
                    a_we            = 1'b1;
                    b_we            = 1'b1;
                    res_status_next = dht_pkg::STATUS_INSERTED;
                    res_slot_next   = loc_reg[dht_pkg::SLOT_W-1:0];
                    state_next      = dht_pkg::ST_FIN;
                end
                else if (op_reg == dht_pkg::OP_SEARCH && !slot_occ)
                begin
                    res_status_next = dht_pkg::STATUS_NOT_FOUND;
                    state_next      = dht_pkg::ST_FIN;
                end
                else if (op_reg == dht_pkg::OP_SEARCH && key_hit)
                begin
                    res_status_next = dht_pkg::STATUS_FOUND;
                    res_slot_next   = loc_reg[dht_pkg::SLOT_W-1:0];
                    res_value_next  = b_rdata;
                    state_next      = dht_pkg::ST_FIN;
                end
                else if (cnt_inc == n_reg)
                begin
                    res_status_next = (op_reg == dht_pkg::OP_INSERT) ?
                                      dht_pkg::STATUS_FULL : dht_pkg::STATUS_NOT_FOUND;
                    state_next      = dht_pkg::ST_FIN;
                end
                else
                begin
                    loc_next = loc_adv;
                    cnt_next = cnt_inc;
                end
            end

            dht_pkg::ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_value_next  = res_value_reg;
                    state_next      = dht_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dht_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        n_reg          <= n_next;
        loc_reg        <= loc_next;
        step_reg       <= step_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_value_reg  <= out_value_next;
    end

    // occupancy bit and key share one word so the clearing sweep covers both
    dht_ram #(
        .WIDTH (KW + 1),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (rd_addr),
        .rdata (a_rdata)
    );

    dht_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (loc_reg[IDX_W-1:0]),
        .wdata (value_reg),
        .raddr (rd_addr),
        .rdata (b_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot        = out_slot_reg;
    assign found_value = out_value_reg;

    // a transfer in always starts the remainder unit
    a_xfer_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == dht_pkg::ST_DIV))
        else $error("accepted request did not enter the remainder phase");

    // probe position and count stay inside the active table
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dht_pkg::ST_CHECK) |-> (loc_reg < n_reg && cnt_reg < n_reg))
        else $error("probe outside the active table");

    // remainder completes only while waiting for it
    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == dht_pkg::ST_DIV))
        else $error("remainder done outside the remainder phase");

    // a search never writes the value memory
    a_search_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dht_pkg::ST_CHECK && op_reg == dht_pkg::OP_SEARCH) |-> !b_we)
        else $error("search wrote the table");

endmodule

// ===== rtl/core/dht_ram.sv =====
// ----------------------------------------------------------------------------
// dht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/dht_mod.sv =====
// ----------------------------------------------------------------------------
// dht_mod
// Iterative remainder unit: key mod n, two restoring steps per cycle.
// ----------------------------------------------------------------------------
module dht_mod #(
    parameter int N_W = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [dht_pkg::KEY_W-1:0] dividend,
    input  logic [N_W-1:0]            divisor,
    output logic                      done,
    output logic [N_W-1:0]            remainder
);

    localparam int ITER  = (dht_pkg::KEY_W + 1) / 2;
    localparam int DVD_W = 2 * ITER;
    localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [N_W-1:0]   rem_reg, rem_next;
    logic [N_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [N_W:0]     trial1, trial2;
    logic [N_W-1:0]   rem1;

    always_comb
    begin
        // first step on the top bit, second on the next one
        trial1 = {rem_reg, dvd_reg[DVD_W-1]};
        if (trial1 >= {1'b0, div_reg})
        begin
            trial1 = trial1 - {1'b0, div_reg};
        end
        rem1 = trial1[N_W-1:0];
        trial2 = {rem1, dvd_reg[DVD_W-2]};
        if (trial2 >= {1'b0, div_reg})
        begin
            trial2 = trial2 - {1'b0, div_reg};
        end

        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            dvd_next  = DVD_W'(dividend);
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-3:0], 2'b00};
            rem_next = trial2[N_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ITER - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
